### design/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define WHS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define WHS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/whs_pkg.sv
// Package: widths, codes and types of the weighted histogram sampler.
`default_nettype none

package whs_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int WEIGHT_BITS_DEF   = 16;

  localparam int OPCODE_W    = 2;
  localparam int BIN_INDEX_W = 8;
  localparam int NEW_WEIGHT_W = 16;
  localparam int FRACTION_W  = 16;
  localparam int CHOSEN_W    = 8;
  localparam int CENTER_W    = 41;
  localparam int TOTAL_OUT_W = 24;
  localparam int LB_W        = 32;
  localparam int BW_W        = 31;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET    = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_LIKELY = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LEFT_EDGE = 1'b0,
    CFG_BIN_WIDTH = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_SCAN,
    ST_PICK,
    ST_PICK_RD,
    ST_CALC,
    ST_WAIT_C,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### design/whs_item_if.sv
// Interfaces: input item channel, result channel and configuration write channel.
`default_nettype none

interface whs_item_if;
  import whs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OPCODE_W-1:0]     opcode;
  logic [BIN_INDEX_W-1:0]  bin_index;
  logic [NEW_WEIGHT_W-1:0] new_weight;
  logic [FRACTION_W-1:0]   random_fraction;

  modport source (output valid, opcode, bin_index, new_weight, random_fraction,
                  input ready);
  modport sink   (input valid, opcode, bin_index, new_weight, random_fraction,
                  output ready);
endinterface

interface whs_result_if;
  import whs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CHOSEN_W-1:0]        chosen_index;
  logic signed [CENTER_W-1:0] bin_center;
  logic                       total_positive;
  logic [TOTAL_OUT_W-1:0]     total_weight;

  modport source (output valid, chosen_index, bin_center, total_positive, total_weight,
                  input ready);
  modport sink   (input valid, chosen_index, bin_center, total_positive, total_weight,
                  output ready);
endinterface

interface whs_cfg_if;
  import whs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/whs_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module whs_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/whs_center.sv
// Bin center unit: left_edge + (index + 0.5) * bin_width over two stages.
`default_nettype none

module whs_center #(
  parameter int IDX_W = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [IDX_W-1:0]                    idx,
  input  wire logic signed [whs_pkg::LB_W-1:0]     left_edge,
  input  wire logic [whs_pkg::BW_W-1:0]            bin_width,
  output logic                                     done,
  output logic signed [whs_pkg::CENTER_W-1:0]      center
);

  import whs_pkg::*;

  localparam int PROD_W = IDX_W + 1 + BW_W;
  localparam int CW     = (IDX_W + 33 > CENTER_W + 1) ? IDX_W + 33 : CENTER_W + 1;

  logic              stage1;
  logic [PROD_W-1:0] prod;
  logic [LB_W-1:0]   lb_q;
  logic [CW-1:0]     sum;

  // Stage 1: odd multiple of the bin width
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'({idx, 1'b1}) * PROD_W'(bin_width);
      lb_q <= left_edge;
    end
  end

  // Twice the center, exact; floor halving is an arithmetic shift
  assign sum = {{(CW-LB_W-1){lb_q[LB_W-1]}}, lb_q, 1'b0}
             + {{(CW-PROD_W){1'b0}}, prod};

  always_ff @(posedge clk) begin
    if (stage1) begin
      center <= sum[CENTER_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      done   <= stage1;
    end
  end

endmodule

`default_nettype wire

### design/weighted_histogram_sampler.sv
// Top level: weight table, scan engine and result register.
// A set reads the old weight, writes the new one and updates the total; a no-op or
// out-of-range set goes straight to the result. Sample and most-likely scan all
// TABLE_ENTRIES weights, one weight read per cycle. Only one item is in work; the next is
// taken in the cycle after the result is loaded, and a waiting result holds the load back.
// Synchronous reset sets config defaults and clears total, then zeroes all TABLE_ENTRIES weights, one a cycle.
`default_nettype none

module weighted_histogram_sampler #(
  parameter int TABLE_ENTRIES = whs_pkg::TABLE_ENTRIES_DEF,
  parameter int WEIGHT_BITS   = whs_pkg::WEIGHT_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  whs_item_if.sink   item,
  whs_result_if.source result,
  whs_cfg_if.sink    cfg
);

  import whs_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int WB    = WEIGHT_BITS;
  localparam int TOT_W = WB + IDX_W;
  localparam int TG_W  = TOT_W + FRACTION_W;
  localparam int BIW   = (IDX_W > BIN_INDEX_W) ? IDX_W : BIN_INDEX_W;
  localparam logic [IDX_W:0]   ENTRIES = (IDX_W+1)'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(TABLE_ENTRIES - 1);

  state_t state, state_next;

  logic signed [LB_W-1:0] left_edge;
  logic [BW_W-1:0]        bin_width;

  op_t               op_q;
  logic [IDX_W-1:0]  bi_q;
  logic [WB-1:0]     nw_q;
  logic [FRACTION_W-1:0] rf_q;
  logic [TG_W-1:0]   target;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  cum;
  logic [TOT_W-1:0]  cum_next;
  logic              found;
  logic [IDX_W-1:0]  chosen;
  logic [WB-1:0]     maxv;
  logic [IDX_W:0]    n_ties;
  logic [IDX_W:0]    cnt;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;

  logic              w_we;
  logic [IDX_W-1:0]  w_waddr;
  logic [WB-1:0]     w_wdata;
  logic [IDX_W-1:0]  w_raddr;
  logic [WB-1:0]     w_rdata;
  logic              t_we;
  logic [IDX_W-1:0]  t_waddr;
  logic [IDX_W-1:0]  t_rdata;

  logic              c_start;
  logic              c_done;
  logic signed [CENTER_W-1:0] c_center;

  logic              item_rdy;
  logic              item_acc;
  logic              load_res;
  logic              is_max;
  logic              is_tie;
  logic              hit;
  logic [WB+4:0]     w20;
  logic [WB+4:0]     max19;
  logic [FRACTION_W+IDX_W:0] pick_prod;
  logic [BIW:0]      bi_ext;
  logic              bi_ok;
  logic [WB+NEW_WEIGHT_W-1:0] nw_ext;
  logic [IDX_W+CHOSEN_W-1:0]  chosen_ext;
  logic [TOT_W+TOTAL_OUT_W-1:0] total_ext;
  logic              is_query;

  whs_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(WB)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  whs_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(IDX_W)) u_tie_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (rd_idx),
    .raddr (pick_prod[FRACTION_W +: IDX_W]),
    .rdata (t_rdata)
  );

  whs_center #(.IDX_W(IDX_W)) u_center (
    .clk       (clk),
    .rst       (rst),
    .start     (c_start),
    .idx       (chosen),
    .left_edge (left_edge),
    .bin_width (bin_width),
    .done      (c_done),
    .center    (c_center)
  );

  // Configuration writes
  assign cfg.ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge <= '0;
      bin_width <= BW_W'(65536);
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_LEFT_EDGE: left_edge <= cfg.data;
        CFG_BIN_WIDTH: bin_width <= cfg.data[BW_W-1:0];
      endcase
    end
  end

  // Item decode
  assign item.ready = item_rdy;
  assign item_acc   = item.valid & item_rdy;
  assign bi_ext     = {{(BIW-BIN_INDEX_W+1){1'b0}}, item.bin_index};
  assign bi_ok      = bi_ext < (BIW+1)'(TABLE_ENTRIES);
  assign nw_ext     = {{WB{1'b0}}, item.new_weight};

  // Scan datapath
  assign cum_next  = cum + TOT_W'(w_rdata);
  assign hit       = target <= {cum_next, {FRACTION_W{1'b0}}};
  assign w20       = ({5'b0, w_rdata} << 4) + ({5'b0, w_rdata} << 2);
  assign max19     = ({5'b0, maxv} << 4) + ({5'b0, maxv} << 1) + {5'b0, maxv};
  assign is_max    = w_rdata > maxv;
  assign is_tie    = w20 >= max19;
  assign pick_prod = (FRACTION_W+IDX_W+1)'(rf_q) * (FRACTION_W+IDX_W+1)'(n_ties);
  assign is_query  = (op_q == OP_SAMPLE) || (op_q == OP_LIKELY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_rdy   = 1'b0;
    w_we       = 1'b0;
    w_waddr    = cnt[IDX_W-1:0];
    w_wdata    = '0;
    w_raddr    = cnt[IDX_W-1:0];
    t_we       = 1'b0;
    t_waddr    = n_ties[IDX_W-1:0];
    c_start    = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        w_we = 1'b1;
        if (cnt[IDX_W-1:0] == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_rdy = ~rst;
        if (item.valid && !rst) begin
          case (op_t'(item.opcode))
            OP_SET:                state_next = bi_ok ? ST_SET_RD : ST_DONE;
            OP_SAMPLE, OP_LIKELY:  state_next = ST_SCAN;
            default:               state_next = ST_DONE;
          endcase
        end
      end
      ST_SET_RD: begin
        w_raddr    = bi_q;
        state_next = ST_SET_WR;
      end
      ST_SET_WR: begin
        w_we       = 1'b1;
        w_waddr    = bi_q;
        w_wdata    = nw_q;
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (op_q == OP_LIKELY && rd_vld) begin
          if (is_max) begin
            t_we    = 1'b1;
            t_waddr = '0;
          end else if (is_tie && n_ties < ENTRIES) begin
            t_we = 1'b1;
          end
        end
        if (cnt == ENTRIES && !rd_vld) begin
          state_next = (op_q == OP_LIKELY) ? ST_PICK : ST_CALC;
        end
      end
      ST_PICK:    state_next = ST_PICK_RD;
      ST_PICK_RD: state_next = ST_CALC;
      ST_CALC: begin
        c_start    = 1'b1;
        state_next = ST_WAIT_C;
      end
      ST_WAIT_C: begin
        if (c_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result.valid || result.ready) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
      total  <= '0;
    end else begin
      case (state)
        ST_CLEAR: cnt <= cnt + (IDX_W+1)'(1);
        ST_IDLE: begin
          if (item_acc) begin
            cnt    <= '0;
            rd_vld <= 1'b0;
          end
        end
        ST_SET_WR: total <= total - TOT_W'(w_rdata) + TOT_W'(nw_q);
        ST_SCAN: begin
          rd_vld <= cnt < ENTRIES;
          if (cnt < ENTRIES) begin
            cnt <= cnt + (IDX_W+1)'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Item fields and scan accumulators
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_acc) begin
          op_q   <= op_t'(item.opcode);
          bi_q   <= bi_ext[IDX_W-1:0];
          nw_q   <= nw_ext[WB-1:0];
          rf_q   <= item.random_fraction;
          target <= TG_W'(item.random_fraction) * TG_W'(total);
          cum    <= '0;
          found  <= 1'b0;
          maxv   <= '0;
          n_ties <= '0;
          chosen <= '0;
        end
      end
      ST_SCAN: begin
        rd_idx <= cnt[IDX_W-1:0];
        if (rd_vld) begin
          cum <= cum_next;
          if (op_q == OP_SAMPLE && hit && !found) begin
            found  <= 1'b1;
            chosen <= rd_idx;
          end
          if (is_max) begin
            maxv   <= w_rdata;
            n_ties <= (IDX_W+1)'(1);
          end else if (is_tie && n_ties < ENTRIES) begin
            n_ties <= n_ties + (IDX_W+1)'(1);
          end
        end
        // A sample scan without a hit falls back to the last bin
        if (cnt == ENTRIES && !rd_vld && op_q == OP_SAMPLE && !found) begin
          chosen <= LAST;
        end
      end
      ST_PICK_RD: chosen <= t_rdata;
      default: ;
    endcase
  end

  // Result register
  assign chosen_ext = {{CHOSEN_W{1'b0}}, chosen};
  assign total_ext  = {{TOTAL_OUT_W{1'b0}}, total};

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_res) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      result.chosen_index   <= is_query ? chosen_ext[CHOSEN_W-1:0] : '0;
      result.bin_center     <= is_query ? c_center : '0;
      result.total_positive <= |total;
      result.total_weight   <= total_ext[TOTAL_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

### design/whs_checker.sv
// Port checker for the weighted histogram sampler, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module whs_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                item_valid,
  input wire logic                                item_ready,
  input wire logic                                res_valid,
  input wire logic                                res_ready,
  input wire logic [whs_pkg::CHOSEN_W-1:0]        chosen_index,
  input wire logic signed [whs_pkg::CENTER_W-1:0] bin_center,
  input wire logic [whs_pkg::TOTAL_OUT_W-1:0]     total_weight
);

  // Reset starts the clear pass, so no item is taken right after it
  `WHS_ASSERT_ALWAYS(a_no_item_after_reset, clk, rst |=> !item_ready, "item taken after reset")

  // One item in work at a time
  `WHS_ASSERT(a_one_in_work, clk, rst, item_valid && item_ready |=> !item_ready, "second item taken while busy")

  `WHS_ASSERT(a_result_held, clk, rst, res_valid && !res_ready |=> res_valid, "result word dropped")

  `WHS_ASSERT(a_result_stable, clk, rst, res_valid && !res_ready |=> $stable(chosen_index) && $stable(bin_center) && $stable(total_weight), "stalled result word changed")

endmodule

bind weighted_histogram_sampler whs_checker u_whs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .chosen_index (result.chosen_index),
  .bin_center   (result.bin_center),
  .total_weight (result.total_weight)
);

`default_nettype wire

### test/whs_sampler_check.sv
// Checker for the weighted histogram sampler: tracks the weight table, predicts and compares.
module whs_sampler_check (
  input  logic   clk,
  input  logic   rst,
  whs_item_if    item,
  whs_result_if  result,
  whs_cfg_if     cfg,
  output int     mismatches,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import whs_pkg::*;

  typedef struct packed {
    logic [CHOSEN_W-1:0]        chosen;
    logic signed [CENTER_W-1:0] center;
    logic                       positive;
    logic [TOTAL_OUT_W-1:0]     total;
  } answer_t;

  bit [WEIGHT_BITS_DEF-1:0] weight_tab [TABLE_ENTRIES_DEF];
  bit [TOTAL_OUT_W-1:0]     weight_sum;
  bit signed [LB_W-1:0]     lower_bound;
  bit [BW_W-1:0]            bin_step;
  answer_t                  awaited_answers [$];
  answer_t                  got, want;

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // First bin whose running sum reaches frac * total / 65536, kept exact.
  function automatic bit [CHOSEN_W-1:0] draw_weighted_bin(bit [FRACTION_W-1:0] frac);
    bit [63:0] target;
    bit [63:0] running;
    target  = 64'(frac) * 64'(weight_sum);
    running = '0;
    for (int k = 0; k < TABLE_ENTRIES_DEF; k++) begin
      running += 64'(weight_tab[k]);
      if (target <= (running << 16)) return CHOSEN_W'(k);
    end
    return CHOSEN_W'(TABLE_ENTRIES_DEF - 1);
  endfunction

  // Bins within 95 percent of the running maximum; pick one by the fraction.
  function automatic bit [CHOSEN_W-1:0] pick_near_max_bin(bit [FRACTION_W-1:0] frac);
    bit [WEIGHT_BITS_DEF-1:0] top;
    bit [CHOSEN_W-1:0]        near [TABLE_ENTRIES_DEF];
    int unsigned              count;
    bit [63:0]                slot;
    top   = '0;
    count = 0;
    for (int k = 0; k < TABLE_ENTRIES_DEF; k++) begin
      if (weight_tab[k] > top) begin
        top     = weight_tab[k];
        near[0] = CHOSEN_W'(k);
        count   = 1;
      end else if (64'(weight_tab[k]) * 20 >= 64'(top) * 19) begin
        near[count] = CHOSEN_W'(k);
        count++;
      end
    end
    if (count > 1) begin
      slot = (64'(frac) * 64'(count)) >> 16;
      return near[slot];
    end
    return near[0];
  endfunction

  function automatic logic signed [CENTER_W-1:0] center_of_bin(bit [CHOSEN_W-1:0] bin);
    longint twice;
    twice = 2 * longint'(lower_bound)
          + longint'(2 * int'(bin) + 1) * longint'(bin_step);
    return CENTER_W'(twice >>> 1);
  endfunction

  function automatic answer_t predict_answer(op_t op, bit [BIN_INDEX_W-1:0] bin,
                                             bit [NEW_WEIGHT_W-1:0] w,
                                             bit [FRACTION_W-1:0] frac);
    answer_t a;
    a = '0;
    case (op)
      OP_SET: begin
        weight_sum      = weight_sum - TOTAL_OUT_W'(weight_tab[bin]) + TOTAL_OUT_W'(w);
        weight_tab[bin] = w;
      end
      OP_SAMPLE, OP_LIKELY: begin
        a.chosen = (op == OP_SAMPLE) ? draw_weighted_bin(frac) : pick_near_max_bin(frac);
        a.center = center_of_bin(a.chosen);
      end
      default: ;
    endcase
    a.positive = (weight_sum != 0);
    a.total    = weight_sum;
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TABLE_ENTRIES_DEF; k++) weight_tab[k] = '0;
      weight_sum  = '0;
      lower_bound = '0;
      bin_step    = BW_W'(65536);
      mismatches  = 0;
      awaited_answers.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_index_t'(cfg.index))
          CFG_LEFT_EDGE: lower_bound = cfg.data;
          CFG_BIN_WIDTH: bin_step    = cfg.data[BW_W-1:0];
          default: ;
        endcase
      end
      // check the result word before queuing a new prediction
      if (result.valid && result.ready) begin
        got.chosen   = result.chosen_index;
        got.center   = result.bin_center;
        got.positive = result.total_positive;
        got.total    = result.total_weight;
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending, index %0d",
                                    got.chosen));
        end else begin
          want = awaited_answers.pop_front();
          if (got.chosen !== want.chosen)
            report_mismatch($sformatf("chosen_index got %0d want %0d",
                                      got.chosen, want.chosen));
          if (got.center !== want.center)
            report_mismatch($sformatf("bin_center got %0d want %0d",
                                      got.center, want.center));
          if (got.positive !== want.positive)
            report_mismatch($sformatf("total_positive got %0b want %0b",
                                      got.positive, want.positive));
          if (got.total !== want.total)
            report_mismatch($sformatf("total_weight got %0d want %0d",
                                      got.total, want.total));
        end
      end
      if (item.valid && item.ready)
        awaited_answers.push_back(predict_answer(op_t'(item.opcode), item.bin_index,
                                                 item.new_weight, item.random_fraction));
    end
    pending = awaited_answers.size();
  end

endmodule

### test/tb_weighted_histogram_sampler.sv
// Testbench top for the weighted histogram sampler: clock, reset, stimulus and verdict.
module tb_weighted_histogram_sampler;
  timeunit 1ns;
  timeprecision 1ps;
  import whs_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  bit               steady;
  int               mismatches;
  int               pending;
  int               sent_by_op [4];
  logic [15:0]      tie_base;

  whs_item_if   item_ch ();
  whs_result_if res_ch ();
  whs_cfg_if    cfg_ch ();

  weighted_histogram_sampler dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  whs_sampler_check sampler_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (res_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #25ms;
    $display("tb_weighted_histogram_sampler NOT OK");
    $finish;
  end

  // result side: stall about one cycle in ten unless in the steady stretch
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = steady || ($urandom_range(99) >= 10);
    end
  end

  // Hold the word until accepted; valid stays high unless the next call idles.
  task automatic put_word(op_t op, logic [7:0] bin, logic [15:0] w, logic [15:0] frac);
    while (!steady && $urandom_range(99) < 10) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid           = 1'b1;
    item_ch.opcode          = op;
    item_ch.bin_index       = bin;
    item_ch.new_weight      = w;
    item_ch.random_fraction = frac;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_by_op[op]++;
  endtask

  task automatic write_setting(logic [31:0] boundary, logic [31:0] step);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = CFG_LEFT_EDGE;
    cfg_ch.data  = boundary;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.index = CFG_BIN_WIDTH;
    cfg_ch.data  = step;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // drain all results, then let the block fall back to idle
  task automatic settle();
    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic directed_words();
    put_word(OP_LIKELY, 8'h00, 16'h0000, 16'h0000);   // empty table: every bin ties
    put_word(OP_LIKELY, 8'hFF, 16'hFFFF, 16'hFFFF);
    put_word(OP_SAMPLE, 8'h00, 16'h0000, 16'h8000);   // zero total picks bin zero
    put_word(OP_SET,    8'd5,  16'd1,    16'hFFFF);
    put_word(OP_SAMPLE, 8'hFF, 16'hFFFF, 16'hFFFF);
    put_word(OP_LIKELY, 8'h00, 16'h0000, 16'h1234);
    put_word(OP_SET,    8'd0,  16'hFFFF, 16'h0000);
    put_word(OP_SET,    8'd255, 16'hFFFF, 16'h0000);
    put_word(OP_SET,    8'd128, 16'd62259, 16'h0000); // just inside 95 percent
    put_word(OP_SET,    8'd64,  16'd62258, 16'h0000); // just outside
    put_word(OP_SAMPLE, 8'h00, 16'h0000, 16'h0000);
    put_word(OP_SAMPLE, 8'h00, 16'h0000, 16'hFFFF);
    put_word(OP_SAMPLE, 8'h00, 16'h0000, 16'h8000);
    put_word(OP_LIKELY, 8'h00, 16'h0000, 16'h0000);
    put_word(OP_LIKELY, 8'h00, 16'h0000, 16'h8000);
    put_word(OP_LIKELY, 8'h00, 16'h0000, 16'hFFFF);
    put_word(OP_NOP,    8'hA5, 16'h5A5A, 16'h3C3C);
    put_word(OP_SET,    8'd0,  16'h0000, 16'h0000);   // drop a weight back to zero
    put_word(OP_LIKELY, 8'h00, 16'h0000, 16'h7FFF);   // max restarts along the scan
    put_word(OP_SAMPLE, 8'h00, 16'h0000, 16'h4000);
    put_word(OP_NOP,    8'h5A, 16'hA5A5, 16'hC3C3);
  endtask

  task automatic random_word();
    op_t         op;
    logic [7:0]  bin;
    logic [15:0] w;
    logic [15:0] frac;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 45)      op = OP_SET;
    else if (pick < 70) op = OP_SAMPLE;
    else if (pick < 92) op = OP_LIKELY;
    else                op = OP_NOP;
    // favor a few bins at both ends so they get rewritten often
    if ($urandom_range(99) < 40)
      bin = $urandom_range(1) ? 8'($urandom_range(7)) : 8'(248 + $urandom_range(7));
    else
      bin = 8'($urandom);
    if ($urandom_range(99) < 3) tie_base = 16'($urandom_range(65535, 20));
    pick = $urandom_range(99);
    if (pick < 20)      w = 16'h0000;
    else if (pick < 24) w = 16'hFFFF;
    else if (pick < 74) w = tie_base - 16'($urandom_range(tie_base / 16));
    else if (pick < 86) w = 16'($urandom_range(15));
    else                w = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 10)      frac = 16'h0000;
    else if (pick < 20) frac = 16'hFFFF;
    else                frac = 16'($urandom);
    put_word(op, bin, w, frac);
  endtask

  initial begin
    item_ch.valid           = 1'b0;
    item_ch.opcode          = OP_NOP;
    item_ch.bin_index       = '0;
    item_ch.new_weight      = '0;
    item_ch.random_fraction = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = CFG_LEFT_EDGE;
    cfg_ch.data             = '0;
    steady                  = 1'b0;
    tie_base                = 16'd40000;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: write_setting(32'h8000_0000, {1'($urandom_range(1)), 31'h7FFF_FFFF});
          2: write_setting(32'h7FFF_FFFF, 32'h8000_0000);
          3: write_setting($urandom, $urandom);
          default: write_setting(32'hFFFF_FFFF, 32'h0000_0001);
        endcase
      end
      steady = (phase == 2);
      if (phase == 0) directed_words();
      repeat (phase == 0 ? 310 : 330) random_word();
    end

    item_ch.valid = 1'b0;
    steady = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("covered %0d set, %0d sample, %0d most-likely and %0d no-op words",
             sent_by_op[OP_SET], sent_by_op[OP_SAMPLE], sent_by_op[OP_LIKELY],
             sent_by_op[OP_NOP]);
    $display("across 5 register settings, including both boundary and width extremes");
    if (mismatches == 0) $display("tb_weighted_histogram_sampler OK");
    else $display("tb_weighted_histogram_sampler NOT OK");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/whs_pkg.sv
design/whs_item_if.sv
design/whs_ram.sv
design/whs_center.sv
design/weighted_histogram_sampler.sv
design/whs_checker.sv
test/whs_sampler_check.sv
test/tb_weighted_histogram_sampler.sv
